// ----- design/sgb_pkg.sv -----
`timescale 1ns / 1ps
package sgb_pkg;

  // Fixed field and datapath widths
  localparam int PIX_W       = 8;
  localparam int NUM_CH      = 3;
  localparam int WT_W        = 16;
  localparam int VAL_W       = 16;
  localparam int ACC_W       = 37;
  localparam int WSUM_W      = 21;
  localparam int DEN_W       = 29;
  localparam int QUO_W       = 16;
  localparam int WIDX_W      = 4;
  localparam int NUM_WREG    = 3;
  localparam int WREG_W      = 64;
  localparam int GEOM_W      = 11;
  localparam int RAD_FIELD_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_MID   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH  = 3'd6;

  // Input opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VTAP,
    ST_VFLUSH,
    ST_VSTART,
    ST_VDIV,
    ST_VDONE,
    ST_HTAP,
    ST_HFLUSH,
    ST_HSTART,
    ST_HDIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_PIX,
    SRC_WIN
  } acc_src_t;

  typedef enum logic {
    DIV_VERT,
    DIV_HORZ
  } div_mode_t;

  typedef struct packed {
    logic              pix_load;
    logic              acc_clear;
    logic              acc_en;
    acc_src_t          acc_src;
    logic [WIDX_W-1:0] wt_idx;
    logic              div_start;
    div_mode_t         div_mode;
    logic              win_shift;
    logic              win_zero;
    logic              lb_we;
    logic              out_load;
    logic              out_done;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- design/sgb_ram.sv -----
`timescale 1ns / 1ps
module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 22528
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/sgb_div.sv -----
`timescale 1ns / 1ps
module sgb_div (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           start,
  input  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::ACC_W-1:0] num,
  input  logic [sgb_pkg::DEN_W-1:0]                      den,
  output logic                                           busy,
  output logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::QUO_W-1:0] quo
);

  localparam int CNT_W  = $clog2(sgb_pkg::QUO_W + 1);
  localparam int HIGH_W = sgb_pkg::ACC_W - sgb_pkg::QUO_W;

  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::QUO_W-1:0] nsh_r, nsh_nxt;
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [sgb_pkg::DEN_W-1:0]                      den_r, den_nxt;
  logic [CNT_W-1:0]                               cnt_r, cnt_nxt;
  logic                                           busy_r, busy_nxt;
  logic [sgb_pkg::DEN_W:0]                        trial;
  logic                                           qbit;

  // One quotient bit per cycle on all lanes, shared divisor
  always_comb begin
    rem_nxt  = rem_r;
    nsh_nxt  = nsh_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = '0;
    qbit     = 1'b0;
    if (start) begin
      for (int c = 0; c < sgb_pkg::NUM_CH; c++) begin
        rem_nxt[c] = {{(sgb_pkg::DEN_W - HIGH_W){1'b0}},
                      num[c][sgb_pkg::ACC_W-1:sgb_pkg::QUO_W]};
        nsh_nxt[c] = num[c][sgb_pkg::QUO_W-1:0];
        quo_nxt[c] = '0;
      end
      den_nxt  = den;
      cnt_nxt  = CNT_W'(sgb_pkg::QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int c = 0; c < sgb_pkg::NUM_CH; c++) begin
        trial = {rem_r[c], nsh_r[c][sgb_pkg::QUO_W-1]};
        qbit  = (trial >= {1'b0, den_r});
        if (qbit) begin
          trial = trial - {1'b0, den_r};
        end
        rem_nxt[c] = trial[sgb_pkg::DEN_W-1:0];
        nsh_nxt[c] = {nsh_r[c][sgb_pkg::QUO_W-2:0], 1'b0};
        quo_nxt[c] = {quo_r[c][sgb_pkg::QUO_W-2:0], qbit};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    nsh_r <= nsh_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ----- design/sgb_dp.sv -----
`timescale 1ns / 1ps
module sgb_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [sgb_pkg::PIX_W-1:0]        in_red,
  input  logic [sgb_pkg::PIX_W-1:0]        in_green,
  input  logic [sgb_pkg::PIX_W-1:0]        in_blue,
  input  sgb_pkg::dp_cmd_t                 cmd,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0] win_idx,
  input  logic [$clog2(2*MAX_RADIUS*MAX_WIDTH)-1:0] lb_raddr,
  input  logic [$clog2(2*MAX_RADIUS*MAX_WIDTH)-1:0] lb_waddr,
  output sgb_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sgb_pkg::PIX_W-1:0]        out_red,
  output logic [sgb_pkg::PIX_W-1:0]        out_green,
  output logic [sgb_pkg::PIX_W-1:0]        out_blue,
  output logic                             out_done
);

  localparam int WIN_D    = 2 * MAX_RADIUS + 1;
  localparam int LS_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;
  localparam int PX3_W    = sgb_pkg::NUM_CH * sgb_pkg::PIX_W;
  localparam int VX3_W    = sgb_pkg::NUM_CH * sgb_pkg::VAL_W;

  logic                                                color_r;
  logic [sgb_pkg::NUM_WREG-1:0][sgb_pkg::WREG_W-1:0]   wreg_r;
  logic [PX3_W-1:0]                                    pix_r;
  logic [VX3_W-1:0]                                    win_r [WIN_D];
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::ACC_W-1:0]      acc_r;
  logic [sgb_pkg::WSUM_W-1:0]                          wsum_r;
  logic                                                out_valid_r;
  logic [sgb_pkg::PIX_W-1:0]                           out_red_r, out_green_r, out_blue_r;
  logic                                                out_done_r;

  logic [PX3_W-1:0]                                    lb_rdata;
  logic [sgb_pkg::WT_W-1:0]                            wt;
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::VAL_W-1:0]      opnd;
  logic [sgb_pkg::NUM_CH-1:0][2*sgb_pkg::WT_W-1:0]     prod;
  logic [VX3_W-1:0]                                    win_rd;
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::ACC_W-1:0]      div_num;
  logic [sgb_pkg::DEN_W-1:0]                           div_den;
  logic                                                div_busy;
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::QUO_W-1:0]      quo;
  logic                                                wsum_zero;
  logic [VX3_W-1:0]                                    vnew;
  logic [sgb_pkg::NUM_CH-1:0][sgb_pkg::PIX_W-1:0]      res;

  // Hold color mode and tap weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= 1'b0;
      wreg_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgb_pkg::CFG_COLOR_MODE:   color_r   <= cfg_data[0];
        sgb_pkg::CFG_WEIGHTS_LOW:  wreg_r[0] <= cfg_data;
        sgb_pkg::CFG_WEIGHTS_MID:  wreg_r[1] <= cfg_data;
        sgb_pkg::CFG_WEIGHTS_HIGH: wreg_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row buffer of the last 2R input rows
  sgb_ram #(
    .WIDTH(PX3_W),
    .DEPTH(LS_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (cmd.lb_we),
    .waddr(lb_waddr),
    .wdata(pix_r),
    .raddr(lb_raddr),
    .rdata(lb_rdata)
  );

  // Select the tap weight; offsets past the last word weigh zero
  always_comb begin
    case (cmd.wt_idx[3:2])
      2'd0:    wt = wreg_r[0][cmd.wt_idx[1:0]*sgb_pkg::WT_W +: sgb_pkg::WT_W];
      2'd1:    wt = wreg_r[1][cmd.wt_idx[1:0]*sgb_pkg::WT_W +: sgb_pkg::WT_W];
      2'd2:    wt = wreg_r[2][cmd.wt_idx[1:0]*sgb_pkg::WT_W +: sgb_pkg::WT_W];
      default: wt = '0;
    endcase
  end

  assign win_rd = win_r[win_idx];

  // Pick the multiply operand per channel
  always_comb begin
    for (int c = 0; c < sgb_pkg::NUM_CH; c++) begin
      case (cmd.acc_src)
        sgb_pkg::SRC_MEM: opnd[c] = {8'b0, lb_rdata[c*sgb_pkg::PIX_W +: sgb_pkg::PIX_W]};
        sgb_pkg::SRC_PIX: opnd[c] = {8'b0, pix_r[c*sgb_pkg::PIX_W +: sgb_pkg::PIX_W]};
        sgb_pkg::SRC_WIN: opnd[c] = win_rd[c*sgb_pkg::VAL_W +: sgb_pkg::VAL_W];
        default:          opnd[c] = '0;
      endcase
      prod[c] = wt * opnd[c];
    end
  end

  // Capture pixel, multiply-accumulate one tap per cycle
  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      pix_r <= {in_blue, in_green, in_red};
    end
    if (cmd.acc_clear) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (cmd.acc_en) begin
      for (int c = 0; c < sgb_pkg::NUM_CH; c++) begin
        acc_r[c] <= acc_r[c] + sgb_pkg::ACC_W'(prod[c]);
      end
      wsum_r <= wsum_r + sgb_pkg::WSUM_W'(wt);
    end
  end

  assign wsum_zero = (wsum_r == '0);

  // Scale the divide: vertical gives 8.8, horizontal strips the fraction
  always_comb begin
    for (int c = 0; c < sgb_pkg::NUM_CH; c++) begin
      if (cmd.div_mode == sgb_pkg::DIV_VERT) begin
        div_num[c] = {acc_r[c][sgb_pkg::ACC_W-9:0], 8'b0};
      end else begin
        div_num[c] = acc_r[c];
      end
    end
    if (cmd.div_mode == sgb_pkg::DIV_VERT) begin
      div_den = sgb_pkg::DEN_W'(wsum_r);
    end else begin
      div_den = {wsum_r, 8'b0};
    end
  end

  sgb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (quo)
  );

  // Push the vertical result into the window
  assign vnew = (cmd.win_zero || wsum_zero) ? '0 : {quo[2], quo[1], quo[0]};

  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      win_r[0] <= vnew;
      for (int i = 1; i < WIN_D; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Clamp the horizontal result and blank green and blue in gray mode
  always_comb begin
    for (int c = 0; c < sgb_pkg::NUM_CH; c++) begin
      if (wsum_zero || (c != 0 && !color_r)) begin
        res[c] = '0;
      end else if (quo[c] > sgb_pkg::QUO_W'(255)) begin
        res[c] = 8'hFF;
      end else begin
        res[c] = quo[c][sgb_pkg::PIX_W-1:0];
      end
    end
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_red_r   <= res[0];
      out_green_r <= res[1];
      out_blue_r  <= res[2];
      out_done_r  <= cmd.out_done;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_done  = out_done_r;

endmodule

// ----- design/sgb_ctrl.sv -----
`timescale 1ns / 1ps
module sgb_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_opcode,
  output logic                              in_stall,
  output sgb_pkg::dp_cmd_t                  cmd,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0] win_idx,
  output logic [$clog2(2*MAX_RADIUS*MAX_WIDTH)-1:0] lb_raddr,
  output logic [$clog2(2*MAX_RADIUS*MAX_WIDTH)-1:0] lb_waddr,
  input  sgb_pkg::dp_stat_t                 stat
);

  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int RADW     = $clog2(MAX_RADIUS + 1);
  localparam int KW       = $clog2(2 * MAX_RADIUS + 1);
  localparam int RW       = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
  localparam int SW       = $clog2(2 * MAX_RADIUS);
  localparam int LS_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;
  localparam int LAW      = $clog2(LS_DEPTH);
  localparam int EW       = ((RW > WW) ? RW : WW) + 2;
  localparam int PW       = 2 * EW;
  localparam int W_RST    = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int H_RST    = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  sgb_pkg::state_t   state_r, state_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic [RADW-1:0]   r_r, r_nxt;
  logic [RW-1:0]     in_row_r, in_row_nxt;
  logic [WW-1:0]     in_col_r, in_col_nxt;
  logic [HW-1:0]     out_row_r, out_row_nxt;
  logic [WW-1:0]     out_col_r, out_col_nxt;
  logic [SW-1:0]     in_slot_r, in_slot_nxt;
  logic [LAW-1:0]    in_base_r, in_base_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [SW-1:0]     rd_slot_r, rd_slot_nxt;
  logic [LAW-1:0]    rd_base_r, rd_base_nxt;
  logic              pend_v_r, pend_v_nxt;
  sgb_pkg::acc_src_t pend_src_r, pend_src_nxt;
  logic [sgb_pkg::WIDX_W-1:0] pend_widx_r, pend_widx_nxt;
  logic [KW-1:0]     pend_win_r, pend_win_nxt;

  logic [EW-1:0] e_inrow, e_incol, e_outrow, e_outcol, e_w, e_h, e_r, e_2r, e_k;
  logic [PW-1:0] pos_e, first_e;
  logic          real_px, vert_on, horiz_on, done, vtap_in, htap_in, last_tap, step_end;
  logic [sgb_pkg::WIDX_W-1:0] widx;
  logic [31:0]   cfg_w, cfg_h, cfg_r;

  // Widen for compares
  assign e_inrow  = EW'(in_row_r);
  assign e_incol  = EW'(in_col_r);
  assign e_outrow = EW'(out_row_r);
  assign e_outcol = EW'(out_col_r);
  assign e_w      = EW'(w_r);
  assign e_h      = EW'(h_r);
  assign e_r      = EW'(r_r);
  assign e_2r     = e_r + e_r;
  assign e_k      = EW'(k_r);

  // Raster position of the step and of the first output, R rows plus R pixels in
  assign pos_e   = PW'(e_inrow) * PW'(e_w) + PW'(e_incol);
  assign first_e = PW'(e_r) * PW'(e_w) + PW'(e_r);

  // Step flags, stable while an item is in flight
  assign real_px  = e_inrow < e_h;
  assign vert_on  = (e_inrow >= e_r) && (e_inrow < e_h + e_r);
  assign horiz_on = (pos_e >= first_e);
  assign done     = (e_outrow == e_h - EW'(1)) && (e_outcol == e_w - EW'(1));
  assign vtap_in  = (e_inrow + e_k >= e_2r) && (e_inrow + e_k < e_h + e_2r);
  assign htap_in  = (e_outcol + e_k >= e_r) && (e_outcol + e_k < e_w + e_r);
  assign last_tap = (e_k == e_2r);
  assign widx     = (e_k >= e_r) ? sgb_pkg::WIDX_W'(e_k - e_r)
                                 : sgb_pkg::WIDX_W'(e_r - e_k);

  // Geometry write values, clamped into range
  always_comb begin
    cfg_w = 32'(cfg_data[sgb_pkg::GEOM_W-1:0]);
    cfg_h = 32'(cfg_data[sgb_pkg::GEOM_W-1:0]);
    cfg_r = 32'(cfg_data[sgb_pkg::RAD_FIELD_W-1:0]);
    if (cfg_w == 32'd0) cfg_w = 32'd1;
    else if (cfg_w > 32'(MAX_WIDTH)) cfg_w = 32'(MAX_WIDTH);
    if (cfg_h == 32'd0) cfg_h = 32'd1;
    else if (cfg_h > 32'(MAX_HEIGHT)) cfg_h = 32'(MAX_HEIGHT);
    if (cfg_r == 32'd0) cfg_r = 32'd1;
    else if (cfg_r > 32'(MAX_RADIUS)) cfg_r = 32'(MAX_RADIUS);
  end

  assign lb_raddr = rd_base_r + LAW'(in_col_r);
  assign lb_waddr = in_base_r + LAW'(in_col_r);
  assign in_stall = (state_r != sgb_pkg::ST_IDLE);

  // Sequencer: next state, tap walk, commands
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    r_nxt         = r_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    in_slot_nxt   = in_slot_r;
    in_base_nxt   = in_base_r;
    k_nxt         = k_r;
    rd_slot_nxt   = rd_slot_r;
    rd_base_nxt   = rd_base_r;
    pend_v_nxt    = 1'b0;
    pend_src_nxt  = pend_src_r;
    pend_widx_nxt = pend_widx_r;
    pend_win_nxt  = pend_win_r;
    step_end      = 1'b0;
    cmd           = '0;
    cmd.acc_en    = pend_v_r;
    cmd.acc_src   = pend_src_r;
    cmd.wt_idx    = pend_widx_r;
    win_idx       = pend_win_r;

    unique case (state_r)
      sgb_pkg::ST_IDLE: begin
        // Drop a drain that arrives before the frame is complete
        if (in_valid && !(in_opcode == sgb_pkg::OP_DRAIN && real_px)) begin
          cmd.pix_load  = 1'b1;
          cmd.acc_clear = 1'b1;
          k_nxt         = '0;
          rd_slot_nxt   = in_slot_r;
          rd_base_nxt   = in_base_r;
          state_nxt     = vert_on ? sgb_pkg::ST_VTAP : sgb_pkg::ST_VDONE;
        end
      end
      sgb_pkg::ST_VTAP: begin
        pend_v_nxt    = vtap_in;
        pend_src_nxt  = last_tap ? sgb_pkg::SRC_PIX : sgb_pkg::SRC_MEM;
        pend_widx_nxt = widx;
        if (EW'(rd_slot_r) + EW'(1) >= e_2r) begin
          rd_slot_nxt = '0;
          rd_base_nxt = '0;
        end else begin
          rd_slot_nxt = rd_slot_r + SW'(1);
          rd_base_nxt = rd_base_r + LAW'(MAX_WIDTH);
        end
        if (last_tap) begin
          state_nxt = sgb_pkg::ST_VFLUSH;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      sgb_pkg::ST_VFLUSH: begin
        state_nxt = sgb_pkg::ST_VSTART;
      end
      sgb_pkg::ST_VSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = sgb_pkg::DIV_VERT;
        state_nxt     = sgb_pkg::ST_VDIV;
      end
      sgb_pkg::ST_VDIV: begin
        cmd.div_mode = sgb_pkg::DIV_VERT;
        if (!stat.div_busy) begin
          state_nxt = sgb_pkg::ST_VDONE;
        end
      end
      sgb_pkg::ST_VDONE: begin
        cmd.win_shift = 1'b1;
        cmd.win_zero  = !vert_on;
        cmd.lb_we     = real_px;
        if (horiz_on) begin
          cmd.acc_clear = 1'b1;
          k_nxt         = '0;
          state_nxt     = sgb_pkg::ST_HTAP;
        end else begin
          step_end  = 1'b1;
          state_nxt = sgb_pkg::ST_IDLE;
        end
      end
      sgb_pkg::ST_HTAP: begin
        pend_v_nxt    = htap_in;
        pend_src_nxt  = sgb_pkg::SRC_WIN;
        pend_widx_nxt = widx;
        pend_win_nxt  = KW'(e_2r - e_k);
        if (last_tap) begin
          state_nxt = sgb_pkg::ST_HFLUSH;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      sgb_pkg::ST_HFLUSH: begin
        state_nxt = sgb_pkg::ST_HSTART;
      end
      sgb_pkg::ST_HSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = sgb_pkg::DIV_HORZ;
        state_nxt     = sgb_pkg::ST_HDIV;
      end
      sgb_pkg::ST_HDIV: begin
        cmd.div_mode = sgb_pkg::DIV_HORZ;
        if (!stat.div_busy) begin
          state_nxt = sgb_pkg::ST_OUT;
        end
      end
      sgb_pkg::ST_OUT: begin
        cmd.div_mode = sgb_pkg::DIV_HORZ;
        cmd.out_done = done;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          step_end     = 1'b1;
          state_nxt    = sgb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgb_pkg::ST_IDLE;
      end
    endcase

    // Advance raster counters at the end of a step
    if (step_end) begin
      if (horiz_on && done) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        in_slot_nxt = '0;
        in_base_nxt = '0;
      end else begin
        if (horiz_on) begin
          if (e_outcol + EW'(1) >= e_w) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + HW'(1);
          end else begin
            out_col_nxt = out_col_r + WW'(1);
          end
        end
        if (e_incol + EW'(1) >= e_w) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + RW'(1);
          if (EW'(in_slot_r) + EW'(1) >= e_2r) begin
            in_slot_nxt = '0;
            in_base_nxt = '0;
          end else begin
            in_slot_nxt = in_slot_r + SW'(1);
            in_base_nxt = in_base_r + LAW'(MAX_WIDTH);
          end
        end else begin
          in_col_nxt = in_col_r + WW'(1);
        end
      end
    end

    // Color mode and geometry writes abandon the frame in progress
    if (cfg_we) begin
      unique case (cfg_index)
        sgb_pkg::CFG_COLOR_MODE:    ;
        sgb_pkg::CFG_FRAME_WIDTH:   w_nxt = WW'(cfg_w);
        sgb_pkg::CFG_FRAME_HEIGHT:  h_nxt = HW'(cfg_h);
        sgb_pkg::CFG_KERNEL_RADIUS: r_nxt = RADW'(cfg_r);
        default: ;
      endcase
      if (cfg_index == sgb_pkg::CFG_COLOR_MODE || cfg_index == sgb_pkg::CFG_FRAME_WIDTH ||
          cfg_index == sgb_pkg::CFG_FRAME_HEIGHT ||
          cfg_index == sgb_pkg::CFG_KERNEL_RADIUS) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        in_slot_nxt = '0;
        in_base_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sgb_pkg::ST_IDLE;
      w_r       <= WW'(W_RST);
      h_r       <= HW'(H_RST);
      r_r       <= RADW'(1);
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      in_slot_r <= '0;
      in_base_r <= '0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      r_r       <= r_nxt;
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      in_slot_r <= in_slot_nxt;
      in_base_r <= in_base_nxt;
      pend_v_r  <= pend_v_nxt;
    end
    k_r         <= k_nxt;
    rd_slot_r   <= rd_slot_nxt;
    rd_base_r   <= rd_base_nxt;
    pend_src_r  <= pend_src_nxt;
    pend_widx_r <= pend_widx_nxt;
    pend_win_r  <= pend_win_nxt;
  end

endmodule

// ----- design/separable_gaussian_blur_top.sv -----
`timescale 1ns / 1ps
// Separable blur over a raster-order frame: a vertical pass over 2R+1 rows, 2R of them
// held in a row buffer, then a horizontal pass over a window of 2R+1 vertical results,
// each normalized by the weights inside the image. One item is handled at a time, by the
// single multiply-accumulate unit that walks 2R+1 taps per pass (R = kernel radius) and
// the radix-2 divider run once per pass. A drain item that comes before the frame is
// complete is taken and dropped. The result register lets the next item start while a
// result waits on out_stall. Output pixel (r,c) comes with the item at raster position
// (r+R)*W + c + R, so feed R rows plus R drain items after the last pixel. Writing color
// mode or geometry restarts the frame; weight writes take effect at once. Write
// configuration only while idle.
module separable_gaussian_blur_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [sgb_pkg::PIX_W-1:0]      in_red_in,
  input  logic [sgb_pkg::PIX_W-1:0]      in_green_in,
  input  logic [sgb_pkg::PIX_W-1:0]      in_blue_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sgb_pkg::PIX_W-1:0]      out_red_out,
  output logic [sgb_pkg::PIX_W-1:0]      out_green_out,
  output logic [sgb_pkg::PIX_W-1:0]      out_blue_out,
  output logic                           out_frame_done
);

  localparam int KW  = $clog2(2 * MAX_RADIUS + 1);
  localparam int LAW = $clog2(2 * MAX_RADIUS * MAX_WIDTH);

  sgb_pkg::dp_cmd_t  cmd;
  sgb_pkg::dp_stat_t stat;
  logic [KW-1:0]     win_idx;
  logic [LAW-1:0]    lb_raddr;
  logic [LAW-1:0]    lb_waddr;

  sgb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .win_idx  (win_idx),
    .lb_raddr (lb_raddr),
    .lb_waddr (lb_waddr),
    .stat     (stat)
  );

  sgb_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_red   (in_red_in),
    .in_green (in_green_in),
    .in_blue  (in_blue_in),
    .cmd      (cmd),
    .win_idx  (win_idx),
    .lb_raddr (lb_raddr),
    .lb_waddr (lb_waddr),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red  (out_red_out),
    .out_green(out_green_out),
    .out_blue (out_blue_out),
    .out_done (out_frame_done)
  );

endmodule
